FILE: rtl/core/rbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_pkg - shared definitions for the bubble route request unit
// Port, status, channel and try-state codes, register map, reset values and
// the structs passed between the top level and the route decision logic.
// ----------------------------------------------------------------------------
package rbr_pkg;

    // default sizes
    localparam int MAX_INPUTS_DEF = 8;
    localparam int DELTA_BITS_DEF = 8;

    // output ports
    localparam logic [2:0] PORT_XP    = 3'd0;
    localparam logic [2:0] PORT_XM    = 3'd1;
    localparam logic [2:0] PORT_YP    = 3'd2;
    localparam logic [2:0] PORT_YM    = 3'd3;
    localparam logic [2:0] PORT_LOCAL = 3'd4;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // output channel codes
    localparam logic [3:0] CH_NONE     = 4'd0;
    localparam logic [3:0] CH_ADAPTIVE = 4'd1;
    localparam logic [3:0] CH_ESCAPE   = 4'd2;

    // arrival channel class
    localparam logic [1:0] CLS_ADAPTIVE = 2'd1;

    // per-input try state
    localparam logic [2:0] TRY_1 = 3'd1;
    localparam logic [2:0] TRY_2 = 3'd2;
    localparam logic [2:0] TRY_3 = 3'd3;
    localparam logic [2:0] TRY_4 = 3'd4;
    localparam logic [2:0] TRY_5 = 3'd5;

    // command codes
    localparam logic CMD_ROUTE   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // register map (byte address = 4 * index)
    localparam int         ADDR_W     = 4;
    localparam logic [1:0] REG_DIR    = 2'd0;
    localparam logic [1:0] REG_CLASS  = 2'd1;
    localparam logic [1:0] REG_INPUTS = 2'd2;
    localparam logic [1:0] REG_LPORTS = 2'd3;

    // register reset values
    localparam logic [2:0] RST_DIR    = PORT_LOCAL;
    localparam logic [1:0] RST_CLASS  = CLS_ADAPTIVE;
    localparam logic [3:0] RST_INPUTS = 4'd1;
    localparam logic [3:0] RST_LPORTS = 4'd1;

    typedef struct packed {
        logic [2:0] dir;
        logic [1:0] cls;
        logic [3:0] inputs;
        logic [3:0] lports;
    } t_cfg;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] port;
        logic [3:0] chan;
        logic       hdr;
        logic       exhausted;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/core/rbr_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_req_if - request channel
// Valid/ready channel carrying one route request beat.
// ----------------------------------------------------------------------------
interface rbr_req_if #(
    parameter int DELTA_BITS = 8
);
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [2:0]                   input_index;
    logic signed [DELTA_BITS-1:0] delta_first;
    logic signed [DELTA_BITS-1:0] delta_second;
    logic                         bubble_x_plus;
    logic                         bubble_x_minus;
    logic                         bubble_y_plus;
    logic                         bubble_y_minus;

    modport source (
        output valid, command, input_index, delta_first, delta_second,
               bubble_x_plus, bubble_x_minus, bubble_y_plus, bubble_y_minus,
        input  ready
    );

    modport sink (
        input  valid, command, input_index, delta_first, delta_second,
               bubble_x_plus, bubble_x_minus, bubble_y_plus, bubble_y_minus,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/rbr_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_rsp_if - result channel
// Valid/ready channel carrying one route result beat.
// ----------------------------------------------------------------------------
interface rbr_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] out_port;
    logic [3:0] out_channel;
    logic       header_used;
    logic       tries_exhausted;

    modport source (
        output valid, status, out_port, out_channel, header_used, tries_exhausted,
        input  ready
    );

    modport sink (
        input  valid, status, out_port, out_channel, header_used, tries_exhausted,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/adaptive_bubble_route_request.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_bubble_route_request - routing request unit of a torus router input
// Registers each request beat, decides the route in one pass and registers
// the result; keeps a try state per multiplexed input.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request beat (command, input number, two header deltas
//   and the four bubble flags); o_rsp returns exactly one result beat for it.
//   Both are valid/ready channels; a beat moves when valid and ready are high.
//   Path: a request is held in the input register, then its result in the
//   result register, where it stays valid until o_rsp takes it.
//   Throughput: one request per cycle while o_rsp is not stalled, set by the
//   single decision pass between the two registers; the per-input try state
//   is read and written in that same cycle, so dependent requests on the
//   same input follow back to back.
//   When o_rsp is stalled the result is held, one more request is taken
//   into the input register, then i_req.ready drops until the result leaves.
//   Reset (i_rst_n low at a clock edge) empties both registers, sets every
//   try state to 1, the local port counter and header flag to 0 and the
//   registers to their defaults. The user writes the registers over the APB port
//   only while the unit is idle; the block does not enforce it. pready is always high.
// ----------------------------------------------------------------------------
module adaptive_bubble_route_request
    import rbr_pkg::*;
#(
    parameter int MAX_INPUTS = MAX_INPUTS_DEF,
    parameter int DELTA_BITS = DELTA_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rbr_req_if.sink           i_req,
    rbr_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    // Reduce the 3-bit input number modulo the input count
    function automatic logic [IDX_W-1:0] idx_mod(input logic [2:0] v);
        logic [4:0] r;
        r = {2'b00, v};
        for (int k = 0; k < 8; k++) begin
            if (r >= 5'(MAX_INPUTS)) begin
                r = r - 5'(MAX_INPUTS);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    // configuration
    t_cfg r_cfg;
    logic cfg_wr;

    // input register
    logic                         r_s1_vld;
    logic                         r_s1_cmd;
    logic [2:0]                   r_s1_idx;
    logic signed [DELTA_BITS-1:0] r_s1_d1;
    logic signed [DELTA_BITS-1:0] r_s1_d2;
    logic [3:0]                   r_s1_flags;

    // result register
    logic    r_out_vld;
    t_result r_res;

    // routing state
    logic [2:0] r_try [MAX_INPUTS];
    logic [3:0] r_cnt;
    logic       r_hdr;

    logic             out_free;
    logic             advance;
    logic             in_take;
    logic [IDX_W-1:0] s1_idx;
    t_result          n_res;
    logic [2:0]       n_try;
    logic [3:0]       n_cnt;
    logic             n_hdr;

    // Handshake
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign advance     = r_s1_vld && out_free;
    assign i_req.ready = !r_s1_vld || out_free;
    assign in_take     = i_req.valid && i_req.ready;
    assign s1_idx      = idx_mod(r_s1_idx);

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_res.status;
    assign o_rsp.out_port        = r_res.port;
    assign o_rsp.out_channel     = r_res.chan;
    assign o_rsp.header_used     = r_res.hdr;
    assign o_rsp.tries_exhausted = r_res.exhausted;

    // Route decision between the two registers
    rbr_route #(
        .DELTA_BITS (DELTA_BITS)
    ) u_route (
        .i_cfg     (r_cfg),
        .i_cmd     (r_s1_cmd),
        .i_dfirst  (r_s1_d1),
        .i_dsecond (r_s1_d2),
        .i_flags   (r_s1_flags),
        .i_try     (r_try[s1_idx]),
        .i_cnt     (r_cnt),
        .i_hdr     (r_hdr),
        .o_res     (n_res),
        .o_try     (n_try),
        .o_cnt     (n_cnt),
        .o_hdr     (n_hdr)
    );

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_DIR:    prdata = {29'd0, r_cfg.dir};
            REG_CLASS:  prdata = {30'd0, r_cfg.cls};
            REG_INPUTS: prdata = {28'd0, r_cfg.inputs};
            REG_LPORTS: prdata = {28'd0, r_cfg.lports};
            default:    prdata = 32'd0;
        endcase
    end

    // Control state, configuration and routing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_cnt         <= 4'd0;
            r_hdr         <= 1'b0;
            r_cfg.dir     <= RST_DIR;
            r_cfg.cls     <= RST_CLASS;
            r_cfg.inputs  <= RST_INPUTS;
            r_cfg.lports  <= RST_LPORTS;
            for (int i = 0; i < MAX_INPUTS; i++) begin
                r_try[i] <= TRY_1;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_DIR:    r_cfg.dir    <= pwdata[2:0];
                    REG_CLASS:  r_cfg.cls    <= pwdata[1:0];
                    REG_INPUTS: r_cfg.inputs <= pwdata[3:0];
                    REG_LPORTS: r_cfg.lports <= pwdata[3:0];
                    default:    r_cfg.dir    <= r_cfg.dir;
                endcase
            end
            if (in_take) begin
                r_s1_vld <= 1'b1;
            end else if (advance) begin
                r_s1_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld     <= 1'b1;
                r_try[s1_idx] <= n_try;
                r_cnt         <= n_cnt;
                r_hdr         <= n_hdr;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd   <= i_req.command;
            r_s1_idx   <= i_req.input_index;
            r_s1_d1    <= i_req.delta_first;
            r_s1_d2    <= i_req.delta_second;
            r_s1_flags <= {i_req.bubble_y_minus, i_req.bubble_y_plus,
                           i_req.bubble_x_minus, i_req.bubble_x_plus};
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

`ifndef SYNTHESIS
    // a stalled request side means both registers are full and the sink waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_s1_vld && r_out_vld && !o_rsp.ready))
        else $error("request ready low without a full, stalled pipeline");

    // an error carries no port and no channel
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_ERROR)
            |-> (o_rsp.out_port == PORT_XP && o_rsp.out_channel == CH_NONE))
        else $error("error result with a port or channel");

    // a refusal is always on an escape channel
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_REFUSED) |-> (o_rsp.out_channel == CH_ESCAPE))
        else $error("refusal on a non-escape channel");

    // a local delivery is granted and names a real port
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.out_port == PORT_LOCAL)
            |-> (o_rsp.status == ST_OK && o_rsp.out_channel != CH_NONE))
        else $error("local delivery without a local port number");

    // reset empties the result register
    assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp.valid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/rbr_route.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_route - route decision for one request
// Walks the try sequence (adaptive X, adaptive Y, escape X, escape Y) from
// the input's current try state, applies the bubble check on escape tries
// and produces the result and the next try, counter and header state.
// ----------------------------------------------------------------------------
module rbr_route
    import rbr_pkg::*;
#(
    parameter int DELTA_BITS = DELTA_BITS_DEF
) (
    input  t_cfg                         i_cfg,
    input  logic                         i_cmd,
    input  logic signed [DELTA_BITS-1:0] i_dfirst,
    input  logic signed [DELTA_BITS-1:0] i_dsecond,
    input  logic [3:0]                   i_flags,
    input  logic [2:0]                   i_try,
    input  logic [3:0]                   i_cnt,
    input  logic                         i_hdr,
    output t_result                      o_res,
    output logic [2:0]                   o_try,
    output logic [3:0]                   o_cnt,
    output logic                         o_hdr
);

    typedef enum logic [1:0] {
        T_ADX,
        T_ADY,
        T_ESX,
        T_ESY
    } t_try;

    localparam logic [DELTA_BITS-1:0] D_ZERO = '0;
    localparam logic [DELTA_BITS-1:0] D_ONE  = DELTA_BITS'(1);
    localparam logic [DELTA_BITS-1:0] D_MONE = '1;

    // Bubble check for an escape request towards tgt
    function automatic logic [1:0] bubble(
        input logic [2:0] dir,
        input logic [1:0] cls,
        input logic [2:0] tgt,
        input logic [3:0] flags
    );
        logic ok;
        ok = flags[tgt[1:0]];
        if (dir == PORT_LOCAL || cls == CLS_ADAPTIVE) begin
            return ok ? ST_OK : ST_REFUSED;
        end else if (dir == tgt) begin
            return ST_OK;
        end else if (tgt == PORT_XP || tgt == PORT_XM) begin
            return ST_ERROR;
        end
        return ok ? ST_OK : ST_REFUSED;
    endfunction

    logic [2:0]                   dir;
    logic                         on_y;
    logic                         one0, one1, has0, has1;
    logic                         has_hx, has_hy;
    logic                         pos0, pos1, pos_hx, pos_hy;
    logic [2:0]                   s;
    logic [2:0]                   after4;
    logic [3:0]                   cnt_base;
    logic [2:0]                   tgt;
    logic [1:0]                   st;
    t_try                         fire;

    // Classify the two deltas
    always_comb begin
        dir    = (i_cfg.dir > PORT_LOCAL) ? PORT_LOCAL : i_cfg.dir;
        on_y   = (dir == PORT_YP) || (dir == PORT_YM);
        one0   = (i_dfirst == D_ONE) || (i_dfirst == D_MONE);
        one1   = (i_dsecond == D_ONE) || (i_dsecond == D_MONE);
        has0   = !(one0 || i_dfirst == D_ZERO);
        has1   = !(one1 || i_dsecond == D_ZERO);
        pos0   = !i_dfirst[DELTA_BITS-1];
        pos1   = !i_dsecond[DELTA_BITS-1];
        has_hx = on_y ? has1 : has0;
        has_hy = on_y ? has0 : has1;
        pos_hx = on_y ? pos1 : pos0;
        pos_hy = on_y ? pos0 : pos1;
        s      = (i_try < TRY_1 || i_try > TRY_5) ? TRY_1 : i_try;
        after4 = (i_cfg.inputs != 4'd1) ? TRY_5 : TRY_1;
    end

    // Pick the first try that finds hops left, starting from the current state
    always_comb begin
        case (s) inside
            TRY_2:   fire = has_hy ? T_ADY : (has0 ? T_ESX : T_ESY);
            TRY_3:   fire = has0 ? T_ESX : T_ESY;
            TRY_4:   fire = has1 ? T_ESY : (has_hx ? T_ADX : T_ADY);
            default: fire = has_hx ? T_ADX : T_ADY;
        endcase
    end

    // Build the result and next state
    always_comb begin
        o_res.status = ST_OK;
        o_res.port   = PORT_XP;
        o_res.chan   = CH_NONE;
        o_try        = s;
        o_cnt        = i_cnt;
        o_hdr        = i_hdr;
        cnt_base     = i_cnt;
        tgt          = PORT_XP;
        st           = ST_OK;

        if (i_cmd == CMD_RESTART) begin
            o_try = TRY_1;
        end else if (one0 && one1) begin
            // arrived: next local port, round robin
            cnt_base   = (i_cnt >= i_cfg.lports) ? 4'd0 : i_cnt;
            o_cnt      = cnt_base + 4'd1;
            o_res.port = PORT_LOCAL;
            o_res.chan = o_cnt;
        end else if (!has0 && !has1) begin
            // no hops left but not arrived
            o_res.status = ST_ERROR;
            o_try        = after4;
            o_hdr        = 1'b1;
        end else begin
            case (fire)
                T_ADX: begin
                    o_hdr      = on_y;
                    o_try      = TRY_2;
                    o_res.chan = CH_ADAPTIVE;
                    if (dir == PORT_LOCAL) begin
                        o_res.port = pos_hx ? PORT_XP : PORT_XM;
                    end else begin
                        o_res.port = dir;
                    end
                end
                T_ADY: begin
                    o_hdr      = !on_y;
                    o_try      = TRY_3;
                    o_res.chan = CH_ADAPTIVE;
                    if (on_y) begin
                        o_res.port = pos_hy ? PORT_XP : PORT_XM;
                    end else begin
                        o_res.port = pos_hy ? PORT_YP : PORT_YM;
                    end
                end
                T_ESX: begin
                    o_hdr        = 1'b0;
                    o_try        = TRY_5;
                    tgt          = pos0 ? PORT_XP : PORT_XM;
                    st           = bubble(dir, i_cfg.cls, tgt, i_flags);
                    o_res.status = st;
                    if (st != ST_ERROR) begin
                        o_res.port = tgt;
                        o_res.chan = CH_ESCAPE;
                    end
                end
                default: begin
                    o_hdr        = 1'b1;
                    o_try        = after4;
                    tgt          = pos1 ? PORT_YP : PORT_YM;
                    st           = bubble(dir, i_cfg.cls, tgt, i_flags);
                    o_res.status = st;
                    o_res.port   = tgt;
                    o_res.chan   = CH_ESCAPE;
                end
            endcase
        end

        o_res.hdr       = o_hdr;
        o_res.exhausted = (o_try == TRY_5);
    end

endmodule
`default_nettype wire
